FILE: design/pcx_pkg.sv
// package for the pcx run-length image decoder
// holds phase and sequencer state types and fixed stream constants; no dependencies

package pcx_pkg;

    // fixed pcx header size and coordinate byte window
    localparam int unsigned HDR_BYTES = 128;
    localparam logic [6:0] HDR_LAST = 7'(HDR_BYTES - 1);
    localparam logic [6:0] HDR_COORD_FIRST = 7'd4;
    localparam logic [6:0] HDR_COORD_LAST = 7'd11;

    // run marker: top two bits set, count in the low six
    localparam logic [1:0] RUN_TAG = 2'b11;

    // result kinds
    localparam logic KIND_SCREEN = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    // palette triple position
    localparam logic [1:0] COLOR_BLUE = 2'd2;

    // stream phase
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_PIXELS  = 5'b00010,
        PH_MARKER  = 5'b00100,
        PH_PALETTE = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    // per-byte sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_PUT  = 3'b100
    } seq_t;

endpackage

FILE: design/pcx_rle_image_decoder.sv
// pcx run-length image decoder, 8 bits per pixel, one file byte per request
// depends on pcx_pkg for phase/sequencer types and stream constants
//
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------
// input     | in_valid / in_ready   | data_byte, first_byte
// output    | out_valid / out_ready | kind, index, value, last
// config    | cfg_write_en          | cfg_write_data (decode enable)
//
// a header, run tag, marker or palette byte is accepted, then executed
// a literal or run value byte also places its pixels, one at a time, and closes
// the pixel loop on the single column step unit: one pixel for a literal, up to
// 63 for a run (32 screen words)
// reset clears the sequencer, phase and counters; no clearing pass
// a full output register that is not taken holds the pixel loop and
// palette writes; the input side is ready only between bytes

module pcx_rle_image_decoder #(
    parameter int unsigned MAX_WIDTH       = 240,
    parameter int unsigned MAX_HEIGHT      = 160,
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [14:0] index,
    output logic [15:0] value,
    output logic        last,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data
);
    import pcx_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned PW = $clog2(PALETTE_ENTRIES + 1);
    localparam logic signed [17:0] MAX_W_S = 18'(MAX_WIDTH);
    localparam logic signed [17:0] MAX_H_S = 18'(MAX_HEIGHT);
    localparam logic [PW-1:0] PAL_LAST = PW'(PALETTE_ENTRIES - 1);

    // state registers
    seq_t          state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic          enable_reg;
    logic [7:0]    byte_reg, byte_next;
    logic          first_reg, first_next;
    logic [6:0]    hcount_reg, hcount_next;
    logic [15:0]   coords_reg [4];
    logic [15:0]   coords_next [4];
    logic [CW-1:0] width_reg, width_next;
    logic [RW-1:0] height_reg, height_next;
    logic          run_pend_reg, run_pend_next;
    logic [5:0]    run_len_reg, run_len_next;
    logic [5:0]    pix_cnt_reg, pix_cnt_next;
    logic [CW-1:0] column_reg, column_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    low_pix_reg, low_pix_next;
    logic [14:0]   word_idx_reg, word_idx_next;
    logic [1:0]    color_part_reg, color_part_next;
    logic [7:0]    red_reg, red_next;
    logic [7:0]    green_reg, green_next;
    logic [PW-1:0] pal_idx_reg, pal_idx_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic          kind_reg, kind_next;
    logic [14:0]   index_reg, index_next;
    logic [15:0]   value_reg, value_next;
    logic          last_reg, last_next;

    logic          out_free;
    logic          emit;
    logic [1:0]    coord_sel;
    logic signed [17:0] x1_s, y1_s, x2_s, y2_s;
    logic signed [17:0] w_raw, w_inc, w_rnd, h_raw;
    logic [CW:0]   col_inc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign index     = index_reg;
    assign value     = value_reg;
    assign last      = last_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // header geometry: sign-extended extents, width rounded up to even
    assign x1_s  = 18'(signed'(coords_reg[0]));
    assign y1_s  = 18'(signed'(coords_reg[1]));
    assign x2_s  = 18'(signed'(coords_reg[2]));
    assign y2_s  = 18'(signed'(coords_reg[3]));
    assign w_raw = x2_s - x1_s + 18'sd1;
    assign h_raw = y2_s - y1_s + 18'sd1;
    assign w_inc = w_raw + 18'sd1;
    assign w_rnd = (w_raw > 18'sd0) ? {w_inc[17:1], 1'b0} : w_raw;

    assign coord_sel = 2'((hcount_reg - HDR_COORD_FIRST) >> 1);
    assign col_inc   = {1'b0, column_reg} + 1'b1;

    // sequencer and per-phase work
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        first_next      = first_reg;
        hcount_next     = hcount_reg;
        coords_next     = coords_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        run_pend_next   = run_pend_reg;
        run_len_next    = run_len_reg;
        pix_cnt_next    = pix_cnt_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        low_pix_next    = low_pix_reg;
        word_idx_next   = word_idx_reg;
        color_part_next = color_part_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        pal_idx_next    = pal_idx_reg;
        emit            = 1'b0;
        kind_next       = kind_reg;
        index_next      = index_reg;
        value_next      = value_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // latch the request; ignored entirely while disabled
                if (in_valid && enable_reg)
                begin
                    byte_next  = data_byte;
                    first_next = first_byte;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (first_reg)
                begin
                    // restart; this byte is header byte zero
                    phase_next      = PH_HEADER;
                    hcount_next     = 7'd1;
                    coords_next     = '{default: 16'd0};
                    width_next      = '0;
                    height_next     = '0;
                    run_pend_next   = 1'b0;
                    run_len_next    = '0;
                    column_next     = '0;
                    row_next        = '0;
                    low_pix_next    = '0;
                    word_idx_next   = '0;
                    color_part_next = '0;
                    red_next        = '0;
                    green_next      = '0;
                    pal_idx_next    = '0;
                end
                else
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            // capture little-endian coordinates
                            if (hcount_reg >= HDR_COORD_FIRST &&
                                hcount_reg <= HDR_COORD_LAST)
                            begin
                                if (hcount_reg[0])
                                    coords_next[coord_sel][15:8] = byte_reg;
                                else
                                    coords_next[coord_sel][7:0] = byte_reg;
                            end
                            hcount_next = hcount_reg + 7'd1;
                            if (hcount_reg == HDR_LAST)
                            begin
                                if (w_rnd > MAX_W_S || h_raw > MAX_H_S)
                                    phase_next = PH_DONE;
                                else
                                begin
                                    width_next  = (w_rnd > 18'sd0) ? CW'(w_rnd) : '0;
                                    height_next = (h_raw > 18'sd0) ? RW'(h_raw) : '0;
                                    if (w_rnd <= 18'sd0 || h_raw <= 18'sd0)
                                        phase_next = PH_MARKER;
                                    else
                                        phase_next = PH_PIXELS;
                                end
                            end
                        end

                        PH_PIXELS:
                        begin
                            if (run_pend_reg)
                            begin
                                run_pend_next = 1'b0;
                                pix_cnt_next  = run_len_reg;
                                state_next    = ST_PUT;
                            end
                            else if (byte_reg[7:6] == RUN_TAG)
                            begin
                                run_pend_next = 1'b1;
                                run_len_next  = byte_reg[5:0];
                            end
                            else
                            begin
                                pix_cnt_next = 6'd1;
                                state_next   = ST_PUT;
                            end
                        end

                        PH_MARKER:
                        begin
                            phase_next = PH_PALETTE;
                        end

                        PH_PALETTE:
                        begin
                            if (color_part_reg == 2'd0)
                            begin
                                red_next        = byte_reg;
                                color_part_next = 2'd1;
                            end
                            else if (color_part_reg == 2'd1)
                            begin
                                green_next      = byte_reg;
                                color_part_next = COLOR_BLUE;
                            end
                            else if (out_free)
                            begin
                                // bgr555 entry
                                emit            = 1'b1;
                                kind_next       = KIND_PALETTE;
                                index_next      = 15'(pal_idx_reg);
                                value_next      = {1'b0, byte_reg[7:3], green_reg[7:3],
                                                   red_reg[7:3]};
                                last_next       = 1'b1;
                                color_part_next = '0;
                                pal_idx_next    = pal_idx_reg + 1'b1;
                                if (pal_idx_reg == PAL_LAST)
                                    phase_next = PH_DONE;
                            end
                            else
                                state_next = ST_EXEC;
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                if (pix_cnt_reg == 6'd0 || column_reg >= width_reg)
                begin
                    // loop done; close the row when it is full
                    state_next = ST_IDLE;
                    if (column_reg >= width_reg)
                    begin
                        column_next = '0;
                        row_next    = row_reg + 1'b1;
                        if (({1'b0, row_reg} + 1'b1) >= {1'b0, height_reg})
                            phase_next = PH_MARKER;
                    end
                end
                else if (!column_reg[0])
                begin
                    // even column: hold the low pixel
                    low_pix_next = byte_reg;
                    column_next  = col_inc[CW-1:0];
                    pix_cnt_next = pix_cnt_reg - 6'd1;
                end
                else if (out_free)
                begin
                    // odd column: emit the pair
                    emit          = 1'b1;
                    kind_next     = KIND_SCREEN;
                    index_next    = word_idx_reg;
                    value_next    = {byte_reg, low_pix_reg};
                    last_next     = (pix_cnt_reg <= 6'd2) ||
                                    (col_inc >= {1'b0, width_reg});
                    word_idx_next = word_idx_reg + 15'd1;
                    column_next   = col_inc[CW-1:0];
                    pix_cnt_next  = pix_cnt_reg - 6'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_HEADER;
            enable_reg     <= 1'b0;
            hcount_reg     <= '0;
            coords_reg     <= '{default: 16'd0};
            width_reg      <= '0;
            height_reg     <= '0;
            run_pend_reg   <= 1'b0;
            run_len_reg    <= '0;
            pix_cnt_reg    <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            word_idx_reg   <= '0;
            color_part_reg <= '0;
            pal_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            if (cfg_write_en)
                enable_reg <= cfg_write_data;
            hcount_reg     <= hcount_next;
            coords_reg     <= coords_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            run_pend_reg   <= run_pend_next;
            run_len_reg    <= run_len_next;
            pix_cnt_reg    <= pix_cnt_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            word_idx_reg   <= word_idx_next;
            color_part_reg <= color_part_next;
            pal_idx_reg    <= pal_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        first_reg   <= first_next;
        low_pix_reg <= low_pix_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    // results appear only out of the execute or pixel loop states
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC || state_reg == ST_PUT))
        else $error("result from idle sequencer");

    // column position never passes the row width
    assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= width_reg)
        else $error("column beyond row width");

    // rows in progress stay inside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (row_reg < height_reg))
        else $error("pixel row beyond image height");

endmodule
